>>> design/multiplexed_clock_display_core_macros.svh
// Assertion macros used by the checker file of the clock display core.
`ifndef MULTIPLEXED_CLOCK_DISPLAY_CORE_MACROS_SVH
`define MULTIPLEXED_CLOCK_DISPLAY_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define MCD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock display check failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define MCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock display check failed");

`endif

>>> design/mcd_pkg.sv
// Types, constants and decode functions of the multiplexed clock display core.
package mcd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int DIGIT_COUNT = 4;
    localparam int SCAN_W      = $clog2(DIGIT_COUNT);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_DELAY   = 3'd0,
        REG_SCAN_PERIOD   = 3'd1,
        REG_DOT_PERIOD    = 3'd2,
        REG_SECOND_PERIOD = 3'd3,
        REG_LED_PERIOD    = 3'd4
    } cfg_reg_t;

    localparam logic [7:0] START_DELAY_RST   = 8'd50;
    localparam logic [7:0] SCAN_PERIOD_RST   = 8'd25;
    localparam logic [7:0] DOT_PERIOD_RST    = 8'd50;
    localparam logic [7:0] SECOND_PERIOD_RST = 8'd100;
    localparam logic [7:0] LED_PERIOD_RST    = 8'd200;

    localparam logic [4:0] HOURS_RST   = 5'd15;
    localparam logic [5:0] MINUTES_RST = 6'd8;
    localparam logic [5:0] SECONDS_RST = 6'd50;

    localparam logic [4:0] HOURS_LAST = 5'd23;
    localparam logic [5:0] MINSEC_LAST = 6'd59;

    localparam logic [3:0] DIGIT_RST [DIGIT_COUNT] = '{4'd1, 4'd5, 4'd0, 4'd8};

    localparam logic [6:0] SEG_BLANK = 7'h7F;

    typedef struct packed {
        logic [6:0] segments;
        logic [3:0] digit_enable;
        logic       dot_level;
        logic       red_led_level;
        logic [4:0] hours_now;
        logic [5:0] minutes_now;
        logic [5:0] seconds_now;
    } result_t;

    // Active-low seven-segment pattern; codes above nine blank the digit.
    function automatic logic [6:0] seg_decode(input logic [3:0] v);
        logic [6:0] s;
        case (v)
            4'd0:    s = 7'h40;
            4'd1:    s = 7'h79;
            4'd2:    s = 7'h24;
            4'd3:    s = 7'h30;
            4'd4:    s = 7'h19;
            4'd5:    s = 7'h12;
            4'd6:    s = 7'h02;
            4'd7:    s = 7'h78;
            4'd8:    s = 7'h00;
            4'd9:    s = 7'h10;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Tens digit of a value below 64, by comparison against the decades.
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] t;
        logic [5:0] u;
        t = {2'b00, tens_of(v)};
        u = v - {t[2:0], 3'b000} - {t[4:0], 1'b0};
        return u[3:0];
    endfunction

endpackage

>>> design/multiplexed_clock_display_core.sv
// Each accepted beat's result is registered in the output stage before it is offered.
// Throughput: one beat per cycle while the skid register is empty; a two-entry output
// stage (result plus skid register) keeps input ready while one result waits downstream.
// Timer, time-of-day and display state advance in the cycle a tick beat is accepted.
// Reset (rst_n low, asynchronous): time 15:08:50, digits 1 5 0 8, all countdowns
// at the start delay, display latches cleared, configuration at its defaults.
module multiplexed_clock_display_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               tick,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [6:0]                         segments,
    output logic [3:0]                         digit_enable,
    output logic                               dot_level,
    output logic                               red_led_level,
    output logic [4:0]                         hours_now,
    output logic [5:0]                         minutes_now,
    output logic [5:0]                         seconds_now
);
    import mcd_pkg::*;

    logic [7:0] start_delay_reg, start_delay_next;
    logic [7:0] scan_period_reg, scan_period_next;
    logic [7:0] dot_period_reg, dot_period_next;
    logic [7:0] second_period_reg, second_period_next;
    logic [7:0] led_period_reg, led_period_next;

    logic [7:0] scan_cnt_reg, scan_cnt_next;
    logic [7:0] dot_cnt_reg, dot_cnt_next;
    logic [7:0] sec_cnt_reg, sec_cnt_next;
    logic [7:0] led_cnt_reg, led_cnt_next;

    logic [4:0] hours_reg, hours_next;
    logic [5:0] minutes_reg, minutes_next;
    logic [5:0] seconds_reg, seconds_next;

    logic [3:0] digit_reg [DIGIT_COUNT];
    logic [3:0] digit_next [DIGIT_COUNT];
    logic [SCAN_W-1:0] scan_idx_reg, scan_idx_next;

    logic [6:0] seg_latch_reg, seg_latch_next;
    logic [3:0] en_latch_reg, en_latch_next;
    logic       dot_latch_reg, dot_latch_next;
    logic       led_latch_reg, led_latch_next;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    logic       accept;
    logic       step;
    logic [7:0] scan_dec, dot_dec, sec_dec, led_dec;
    logic       scan_hit, dot_hit, sec_hit, led_hit;
    logic       minute_roll;
    result_t    result;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign step     = accept && tick;

    // Countdowns wrap from zero, so a period of zero lasts 256 ticks.
    assign scan_dec = scan_cnt_reg - 8'd1;
    assign dot_dec  = dot_cnt_reg - 8'd1;
    assign sec_dec  = sec_cnt_reg - 8'd1;
    assign led_dec  = led_cnt_reg - 8'd1;
    assign scan_hit = (scan_dec == 8'd0);
    assign dot_hit  = (dot_dec == 8'd0);
    assign sec_hit  = (sec_dec == 8'd0);
    assign led_hit  = (led_dec == 8'd0);

    assign minute_roll = sec_hit && (seconds_reg >= MINSEC_LAST);

    always_comb
    begin
        start_delay_next   = start_delay_reg;
        scan_period_next   = scan_period_reg;
        dot_period_next    = dot_period_reg;
        second_period_next = second_period_reg;
        led_period_next    = led_period_reg;
        scan_cnt_next      = scan_cnt_reg;
        dot_cnt_next       = dot_cnt_reg;
        sec_cnt_next       = sec_cnt_reg;
        led_cnt_next       = led_cnt_reg;
        hours_next         = hours_reg;
        minutes_next       = minutes_reg;
        seconds_next       = seconds_reg;
        digit_next         = digit_reg;
        scan_idx_next      = scan_idx_reg;
        seg_latch_next     = seg_latch_reg;
        en_latch_next      = en_latch_reg;
        dot_latch_next     = dot_latch_reg;
        led_latch_next     = led_latch_reg;

        if (step)
        begin
            scan_cnt_next = scan_hit ? scan_period_reg : scan_dec;
            dot_cnt_next  = dot_hit ? dot_period_reg : dot_dec;
            sec_cnt_next  = sec_hit ? second_period_reg : sec_dec;
            led_cnt_next  = led_hit ? led_period_reg : led_dec;

            // The scan reads the buffer as it stood before any minute refresh.
            if (scan_hit)
            begin
                en_latch_next  = ~(4'b0001 << scan_idx_reg);
                seg_latch_next = seg_decode(digit_reg[scan_idx_reg]);
                scan_idx_next  = scan_idx_reg + SCAN_W'(1);
            end
            if (dot_hit)
            begin
                dot_latch_next = !dot_latch_reg;
            end
            if (led_hit)
            begin
                led_latch_next = !led_latch_reg;
            end
            if (sec_hit)
            begin
                seconds_next = minute_roll ? 6'd0 : seconds_reg + 6'd1;
            end
            if (minute_roll)
            begin
                if (minutes_reg >= MINSEC_LAST)
                begin
                    minutes_next = 6'd0;
                    hours_next   = (hours_reg >= HOURS_LAST) ? 5'd0 : hours_reg + 5'd1;
                end
                else
                begin
                    minutes_next = minutes_reg + 6'd1;
                end
                digit_next[0] = tens_of({1'b0, hours_next});
                digit_next[1] = units_of({1'b0, hours_next});
                digit_next[2] = tens_of(minutes_next);
                digit_next[3] = units_of(minutes_next);
            end
        end

        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_START_DELAY:
                begin
                    start_delay_next = cfg_data;
                    scan_cnt_next    = cfg_data;
                    dot_cnt_next     = cfg_data;
                    sec_cnt_next     = cfg_data;
                    led_cnt_next     = cfg_data;
                end
                REG_SCAN_PERIOD:   scan_period_next   = cfg_data;
                REG_DOT_PERIOD:    dot_period_next    = cfg_data;
                REG_SECOND_PERIOD: second_period_next = cfg_data;
                REG_LED_PERIOD:    led_period_next    = cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        result.segments      = seg_latch_next;
        result.digit_enable  = en_latch_next;
        result.dot_level     = dot_latch_next;
        result.red_led_level = led_latch_next;
        result.hours_now     = hours_next;
        result.minutes_now   = minutes_next;
        result.seconds_now   = seconds_next;
    end

    // The skid register only fills when a beat arrives while the result register
    // is held; input ready drops until it drains.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                if (accept)
                begin
                    out_data_next = result;
                end
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg   <= START_DELAY_RST;
            scan_period_reg   <= SCAN_PERIOD_RST;
            dot_period_reg    <= DOT_PERIOD_RST;
            second_period_reg <= SECOND_PERIOD_RST;
            led_period_reg    <= LED_PERIOD_RST;
            scan_cnt_reg      <= START_DELAY_RST;
            dot_cnt_reg       <= START_DELAY_RST;
            sec_cnt_reg       <= START_DELAY_RST;
            led_cnt_reg       <= START_DELAY_RST;
            hours_reg         <= HOURS_RST;
            minutes_reg       <= MINUTES_RST;
            seconds_reg       <= SECONDS_RST;
            digit_reg         <= DIGIT_RST;
            scan_idx_reg      <= '0;
            seg_latch_reg     <= '0;
            en_latch_reg      <= '0;
            dot_latch_reg     <= 1'b0;
            led_latch_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            start_delay_reg   <= start_delay_next;
            scan_period_reg   <= scan_period_next;
            dot_period_reg    <= dot_period_next;
            second_period_reg <= second_period_next;
            led_period_reg    <= led_period_next;
            scan_cnt_reg      <= scan_cnt_next;
            dot_cnt_reg       <= dot_cnt_next;
            sec_cnt_reg       <= sec_cnt_next;
            led_cnt_reg       <= led_cnt_next;
            hours_reg         <= hours_next;
            minutes_reg       <= minutes_next;
            seconds_reg       <= seconds_next;
            digit_reg         <= digit_next;
            scan_idx_reg      <= scan_idx_next;
            seg_latch_reg     <= seg_latch_next;
            en_latch_reg      <= en_latch_next;
            dot_latch_reg     <= dot_latch_next;
            led_latch_reg     <= led_latch_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign segments      = out_data_reg.segments;
    assign digit_enable  = out_data_reg.digit_enable;
    assign dot_level     = out_data_reg.dot_level;
    assign red_led_level = out_data_reg.red_led_level;
    assign hours_now     = out_data_reg.hours_now;
    assign minutes_now   = out_data_reg.minutes_now;
    assign seconds_now   = out_data_reg.seconds_now;

endmodule

>>> design/mcd_checker.sv
// Port-level checker for the clock display core and its bind statement.
`include "multiplexed_clock_display_core_macros.svh"

module mcd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] segments,
    input logic [3:0] digit_enable,
    input logic       dot_level,
    input logic       red_led_level,
    input logic [4:0] hours_now,
    input logic [5:0] minutes_now,
    input logic [5:0] seconds_now
);
    import mcd_pkg::*;

    logic [29:0] out_bits;
    logic        digit_sel_ok;
    logic        time_in_range;

    assign out_bits = {segments, digit_enable, dot_level, red_led_level,
                       hours_now, minutes_now, seconds_now};

    // Before the first scan the enable latch reads zero; after it exactly one digit is selected.
    assign digit_sel_ok = (digit_enable == 4'h0) || $onehot(~digit_enable);

    assign time_in_range = (hours_now <= HOURS_LAST) && (minutes_now <= MINSEC_LAST)
                           && (seconds_now <= MINSEC_LAST);

    // Every accepted beat leaves a result on offer in the next cycle.
    `MCD_ASSERT_NEXT(a_accept_gives_result, in_valid && in_ready, out_valid)

    // A held result keeps every field.
    `MCD_ASSERT_NEXT(a_stall_holds_result, out_valid && !out_ready, $stable(out_bits))

    `MCD_ASSERT_NOW(a_one_digit, out_valid, digit_sel_ok)

    // The time of day never leaves its range.
    `MCD_ASSERT_NOW(a_time_range, out_valid, time_in_range)

endmodule

bind multiplexed_clock_display_core mcd_checker u_mcd_checker (.*);

>>> tb/tb_multiplexed_clock_display_core.sv
`timescale 1ns / 100ps
// Self-checking testbench of the clock display core: random ticks, settings and flow control.
module tb_multiplexed_clock_display_core;
    import mcd_pkg::*;

    localparam int HOLD_CYCLES     = 64;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BEATS     = 200;
    localparam int SHOWN_ERRORS    = 100;
    localparam int CLOCK_RUN_BEATS = 150;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = 3'd7;
    localparam logic [6:0] DIGIT_FONT [10] = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19,
                                               7'h12, 7'h02, 7'h78, 7'h00, 7'h10};

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic                   tick      = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [6:0]             segments;
    logic [3:0]             digit_enable;
    logic                   dot_level;
    logic                   red_led_level;
    logic [4:0]             hours_now;
    logic [5:0]             minutes_now;
    logic [5:0]             seconds_now;

    multiplexed_clock_display_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .tick          (tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .segments      (segments),
        .digit_enable  (digit_enable),
        .dot_level     (dot_level),
        .red_led_level (red_led_level),
        .hours_now     (hours_now),
        .minutes_now   (minutes_now),
        .seconds_now   (seconds_now)
    );

    // Predicted display state.
    logic [7:0] delay_cfg, scan_cfg, dot_cfg, second_cfg, led_cfg;
    logic [7:0] scan_left, dot_left, second_left, led_left;
    logic [4:0] hours_m;
    logic [5:0] minutes_m, seconds_m;
    logic [3:0] digit_buf [DIGIT_COUNT];
    logic [1:0] scan_pos;
    logic [6:0] seg_m;
    logic [3:0] enable_m;
    logic       dot_m, led_m;

    result_t display_expect_q[$];
    bit      tick_backlog[$];
    int      error_count = 0;
    bit      in_fire_seen = 1'b0;

    // Sender and receiver shaping, set between phases.
    int          gap_max = 0, burst_max = 1;
    int          gap_left = 0, burst_left = 1;
    logic [15:0] stall_pattern = '1;
    int          pattern_pos = 0;
    int          hold_requests = 0, holds_served = 0, hold_left = 0;

    function automatic void load_digit_buffer();
        digit_buf[0] = 4'(hours_m / 5'd10);
        digit_buf[1] = 4'(hours_m % 5'd10);
        digit_buf[2] = 4'(minutes_m / 6'd10);
        digit_buf[3] = 4'(minutes_m % 6'd10);
    endfunction

    function automatic void reload_countdowns();
        scan_left   = delay_cfg;
        dot_left    = delay_cfg;
        second_left = delay_cfg;
        led_left    = delay_cfg;
    endfunction

    function automatic void reset_display_model();
        delay_cfg  = START_DELAY_RST;
        scan_cfg   = SCAN_PERIOD_RST;
        dot_cfg    = DOT_PERIOD_RST;
        second_cfg = SECOND_PERIOD_RST;
        led_cfg    = LED_PERIOD_RST;
        hours_m    = HOURS_RST;
        minutes_m  = MINUTES_RST;
        seconds_m  = SECONDS_RST;
        load_digit_buffer();
        scan_pos   = '0;
        reload_countdowns();
        seg_m      = '0;
        enable_m   = '0;
        dot_m      = 1'b0;
        led_m      = 1'b0;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [7:0] value);
        case (idx)
            REG_START_DELAY:
            begin
                delay_cfg = value;
                reload_countdowns();
            end
            REG_SCAN_PERIOD:   scan_cfg = value;
            REG_DOT_PERIOD:    dot_cfg = value;
            REG_SECOND_PERIOD: second_cfg = value;
            REG_LED_PERIOD:    led_cfg = value;
            default:           ;
        endcase
    endfunction

    // A countdown at one expires on this tick; zero wraps to 255 and so lasts 256 ticks.
    function automatic logic [7:0] count_down(input logic [7:0] left, input logic [7:0] period);
        return (left == 8'd1) ? period : left - 8'd1;
    endfunction

    function automatic result_t advance_display(input logic tick_in);
        result_t r;
        logic    scan_hit, dot_hit, sec_hit, led_hit;
        if (tick_in)
        begin
            scan_hit    = (scan_left == 8'd1);
            dot_hit     = (dot_left == 8'd1);
            sec_hit     = (second_left == 8'd1);
            led_hit     = (led_left == 8'd1);
            scan_left   = count_down(scan_left, scan_cfg);
            dot_left    = count_down(dot_left, dot_cfg);
            second_left = count_down(second_left, second_cfg);
            led_left    = count_down(led_left, led_cfg);
            // The scan step shows the buffer as it was before any refresh on this tick.
            if (scan_hit)
            begin
                enable_m = ~(4'b0001 << scan_pos);
                seg_m    = (digit_buf[scan_pos] <= 4'd9) ? DIGIT_FONT[digit_buf[scan_pos]]
                                                         : SEG_BLANK;
                scan_pos = scan_pos + 2'd1;
            end
            if (dot_hit)
                dot_m = ~dot_m;
            if (sec_hit)
            begin
                if (seconds_m == MINSEC_LAST)
                begin
                    seconds_m = '0;
                    if (minutes_m == MINSEC_LAST)
                    begin
                        minutes_m = '0;
                        hours_m   = (hours_m == HOURS_LAST) ? 5'd0 : hours_m + 5'd1;
                    end
                    else
                        minutes_m = minutes_m + 6'd1;
                    load_digit_buffer();
                end
                else
                    seconds_m = seconds_m + 6'd1;
            end
            if (led_hit)
                led_m = ~led_m;
        end
        r.segments      = seg_m;
        r.digit_enable  = enable_m;
        r.dot_level     = dot_m;
        r.red_led_level = led_m;
        r.hours_now     = hours_m;
        r.minutes_now   = minutes_m;
        r.seconds_now   = seconds_m;
        return r;
    endfunction

    // Mostly short periods so that the timers fire often, with the extremes mixed in.
    function automatic logic [7:0] pick_period();
        logic [7:0] v;
        case ($urandom_range(9))
            0:       v = 8'd0;
            1:       v = 8'd1;
            2:       v = 8'd255;
            3, 4, 5: v = 8'($urandom_range(1, 4));
            6, 7:    v = 8'($urandom_range(5, 20));
            default: v = 8'($urandom_range(255));
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < SHOWN_ERRORS)
            $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        apply_register(idx, value);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain_pipeline();
        do
            @(posedge clk);
        while (tick_backlog.size() != 0 || in_valid || display_expect_q.size() != 0);
    endtask

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Sender: bursts of beats separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire_seen)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (tick_backlog.size() != 0)
            begin
                in_valid <= 1'b1;
                tick     <= tick_backlog.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, burst_max);
                    gap_left   = $urandom_range(0, gap_max);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stalls follow a rotating pattern, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready   <= stall_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 16;
        end
    end

    // The result leaving at this edge belongs to an earlier beat, so it is checked first.
    always @(posedge clk)
    begin
        result_t seen, want;
        in_fire_seen = rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            seen.segments      = segments;
            seen.digit_enable  = digit_enable;
            seen.dot_level     = dot_level;
            seen.red_led_level = red_led_level;
            seen.hours_now     = hours_now;
            seen.minutes_now   = minutes_now;
            seen.seconds_now   = seconds_now;
            if (display_expect_q.size() == 0)
                report_mismatch("result with nothing expected", 1, 0);
            else
            begin
                want = display_expect_q.pop_front();
                if (seen.segments !== want.segments)
                    report_mismatch("segments", int'(seen.segments), int'(want.segments));
                if (seen.digit_enable !== want.digit_enable)
                    report_mismatch("digit_enable", int'(seen.digit_enable),
                                    int'(want.digit_enable));
                if (seen.dot_level !== want.dot_level)
                    report_mismatch("dot_level", int'(seen.dot_level), int'(want.dot_level));
                if (seen.red_led_level !== want.red_led_level)
                    report_mismatch("red_led_level", int'(seen.red_led_level),
                                    int'(want.red_led_level));
                if (seen.hours_now !== want.hours_now)
                    report_mismatch("hours_now", int'(seen.hours_now), int'(want.hours_now));
                if (seen.minutes_now !== want.minutes_now)
                    report_mismatch("minutes_now", int'(seen.minutes_now),
                                    int'(want.minutes_now));
                if (seen.seconds_now !== want.seconds_now)
                    report_mismatch("seconds_now", int'(seen.seconds_now),
                                    int'(want.seconds_now));
            end
        end
        if (in_fire_seen)
            display_expect_q.push_back(advance_display(tick));
    end

    initial
    begin
        cfg_reg_t period_regs [4];
        period_regs = '{REG_SCAN_PERIOD, REG_DOT_PERIOD, REG_SECOND_PERIOD, REG_LED_PERIOD};
        reset_display_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Idle beats still return the reset display, then one tick far from any expiry.
        tick_backlog = '{1'b0, 1'b0, 1'b1};
        drain_pipeline();

        // Fast scan, dot and second timers: a scan on each tick, a minute change after ten seconds,
        // so the scan and the digit refresh land on the same tick.
        write_register(REG_SCAN_PERIOD, 8'd1);
        write_register(REG_DOT_PERIOD, 8'd2);
        write_register(REG_SECOND_PERIOD, 8'd1);
        write_register(REG_LED_PERIOD, 8'd255);
        write_register(REG_START_DELAY, 8'd1);
        write_register(REG_UNUSED_FIRST, 8'hA5);
        for (int i = 0; i < 16; i++)
            tick_backlog.push_back(i != 4 && i != 9);
        drain_pipeline();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    gap_max       = 0;
                    burst_max     = 1;
                    stall_pattern = '1;
                end
                1:
                begin
                    gap_max       = 3;
                    burst_max     = 6;
                    stall_pattern = 16'($urandom) | 16'h0101;
                end
                2:
                begin
                    gap_max       = 8;
                    burst_max     = 3;
                    stall_pattern = 16'($urandom) | 16'h1000;
                end
                default:
                begin
                    gap_max       = 0;
                    burst_max     = 1;
                    stall_pattern = 16'($urandom) | 16'h0011;
                end
            endcase
            foreach (period_regs[r])
                if (p == 0 || $urandom_range(3) != 0)
                    write_register(period_regs[r], pick_period());
            if (p == 1)
                write_register(REG_START_DELAY, 8'd0);
            else if (p == 2)
                write_register(REG_START_DELAY, 8'd255);
            else if ($urandom_range(1) == 0)
                write_register(REG_START_DELAY, pick_period());
            if ($urandom_range(2) == 0)
                write_register(3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                               8'($urandom_range(255)));
            for (int i = 0; i < PHASE_BEATS; i++)
                tick_backlog.push_back($urandom_range(9) != 0);
            // Hold the output back while the sender keeps offering beats.
            if (p % 4 == 3)
                hold_requests++;
            drain_pipeline();
        end

        // One counted second per tick without any idling, across several minute changes.
        gap_max       = 0;
        burst_max     = 1;
        stall_pattern = '1;
        write_register(REG_SCAN_PERIOD, 8'd0);
        write_register(REG_DOT_PERIOD, 8'd255);
        write_register(REG_SECOND_PERIOD, 8'd1);
        write_register(REG_LED_PERIOD, 8'($urandom_range(255)));
        write_register(REG_START_DELAY, 8'd1);
        repeat (CLOCK_RUN_BEATS) tick_backlog.push_back(1'b1);
        drain_pipeline();

        repeat (8) @(posedge clk);
        if (display_expect_q.size() != 0)
            report_mismatch("results never produced", display_expect_q.size(), 0);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> multiplexed_clock_display_core.f
+incdir+design
design/mcd_pkg.sv
design/multiplexed_clock_display_core.sv
design/mcd_checker.sv
tb/tb_multiplexed_clock_display_core.sv
